// ===== src/lfuttl_pkg.sv =====
package lfuttl_pkg;

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int LIFE_W = 31;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [VAL_W-1:0] READ_MISS = '1;

    typedef enum logic [1:0] {
        OP_GET  = 2'd0,
        OP_PUT  = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [KEY_W-1:0]  key;
        logic signed [VAL_W-1:0]  data_value;
        logic [LIFE_W-1:0]        lifetime;
    } t_cmd;

    typedef struct packed {
        logic                     hit;
        logic signed [VAL_W-1:0]  read_value;
        logic                     evicted;
        logic signed [KEY_W-1:0]  evicted_key;
    } t_result;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_WRITE,
        ST_SWEEP,
        ST_SWEEP_END,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic match_found;
        logic free_found;
    } t_scan_flags;

endpackage

// ===== src/lfuttl_ram.sv =====
module lfuttl_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lfuttl_scan.sv =====
module lfuttl_scan #(
    parameter int ENTRIES   = 16,
    parameter int TIME_BITS = 48,
    parameter int USE_BITS  = 16,
    parameter int UW        = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_probe,
    input  logic [$clog2(ENTRIES)-1:0] i_idx,
    input  logic                       i_valid,
    input  logic [31:0]                i_key,
    input  logic [31:0]                i_value,
    input  logic [TIME_BITS-1:0]       i_deadline,
    input  logic [USE_BITS-1:0]        i_uses,
    input  logic [$clog2(ENTRIES)-1:0] i_order,
    input  logic [31:0]                i_search_key,
    input  logic [TIME_BITS-1:0]       i_time,
    input  logic [UW-1:0]              i_usable,
    output logic                       o_expire,
    output lfuttl_pkg::t_scan_flags    o_flags,
    output logic [$clog2(ENTRIES)-1:0] o_match_slot,
    output logic [31:0]                o_match_value,
    output logic [TIME_BITS-1:0]       o_match_deadline,
    output logic [USE_BITS-1:0]        o_match_uses,
    output logic [$clog2(ENTRIES)-1:0] o_match_order,
    output logic [$clog2(ENTRIES)-1:0] o_free_slot,
    output logic [$clog2(ENTRIES)-1:0] o_free_order,
    output logic [$clog2(ENTRIES)-1:0] o_vict_slot,
    output logic [31:0]                o_vict_key,
    output logic [$clog2(ENTRIES)-1:0] o_vict_order
);

    import lfuttl_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    logic              r_match_found;
    logic              r_free_found;
    logic              r_vict_found;
    logic [IDX_W-1:0]  r_match_slot;
    logic [31:0]       r_match_value;
    logic [TIME_BITS-1:0] r_match_deadline;
    logic [USE_BITS-1:0]  r_match_uses;
    logic [IDX_W-1:0]  r_match_order;
    logic [IDX_W-1:0]  r_free_slot;
    logic [IDX_W-1:0]  r_free_order;
    logic [IDX_W-1:0]  r_vict_slot;
    logic [31:0]       r_vict_key;
    logic [USE_BITS-1:0]  r_vict_uses;
    logic [IDX_W-1:0]  r_vict_order;

    logic w_live;
    logic w_in_cap;
    logic w_take_match;
    logic w_take_free;
    logic w_take_vict;

    assign w_live   = i_valid && (i_deadline > i_time);
    assign w_in_cap = UW'(i_idx) < i_usable;
    assign o_expire = i_probe && i_valid && !w_live;

    assign w_take_match = i_probe && w_live && (i_key == i_search_key) && !r_match_found;
    assign w_take_free  = i_probe && w_in_cap && !w_live && !r_free_found;
    // lowest use count wins, older touch breaks a tie
    assign w_take_vict  = i_probe && w_in_cap && w_live &&
                          (!r_vict_found || (i_uses < r_vict_uses) ||
                           ((i_uses == r_vict_uses) && (i_order < r_vict_order)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_vict_found  <= 1'b0;
        end else begin
            if (w_take_match) r_match_found <= 1'b1;
            if (w_take_free)  r_free_found  <= 1'b1;
            if (w_take_vict)  r_vict_found  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_match) begin
            r_match_slot     <= i_idx;
            r_match_value    <= i_value;
            r_match_deadline <= i_deadline;
            r_match_uses     <= i_uses;
            r_match_order    <= i_order;
        end
        if (w_take_free) begin
            r_free_slot  <= i_idx;
            r_free_order <= i_order;
        end
        if (w_take_vict) begin
            r_vict_slot  <= i_idx;
            r_vict_key   <= i_key;
            r_vict_uses  <= i_uses;
            r_vict_order <= i_order;
        end
    end

    assign o_flags.match_found = r_match_found;
    assign o_flags.free_found  = r_free_found;
    assign o_match_slot        = r_match_slot;
    assign o_match_value       = r_match_value;
    assign o_match_deadline    = r_match_deadline;
    assign o_match_uses        = r_match_uses;
    assign o_match_order       = r_match_order;
    assign o_free_slot         = r_free_slot;
    assign o_free_order        = r_free_order;
    assign o_vict_slot         = r_vict_slot;
    assign o_vict_key          = r_vict_key;
    assign o_vict_order        = r_vict_order;

endmodule

// ===== src/lfu_cache_with_ttl_top.sv =====
// LFU key-value cache with a lifetime per entry. Raise start with a get, put or
// tick on i_cmd while busy is low; the result comes back on o_result for exactly
// one cycle with o_result_valid high, and it cannot be held off, so capture it
// then. All entries live in one single-port-read memory that is walked one
// entry per cycle: a get or put scans every entry (key match, expiry, free slot
// and least-used victim); a get that hits or a put then writes the chosen entry
// and walks the memory again to age the recency ranks, while a get that misses
// ends after the scan. A tick, an unknown opcode or a put at zero capacity
// skips the memory. After reset the block stays busy while it sets up the
// memory; capacity writes are taken at any time but belong in idle periods.
module lfu_cache_with_ttl_top #(
    parameter int ENTRIES   = 16,
    parameter int TIME_BITS = 48,
    parameter int USE_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  lfuttl_pkg::t_cmd                     i_cmd,
    output logic                                 busy,
    output logic                                 o_result_valid,
    output lfuttl_pkg::t_result                  o_result,
    input  logic                                 i_cfg_we,
    input  logic [lfuttl_pkg::CAP_W-1:0]         i_cfg_wdata
);

    import lfuttl_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int UW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int SUM_W  = ((TIME_BITS > LIFE_W) ? TIME_BITS : LIFE_W) + 1;
    localparam int O_USE  = IDX_W;
    localparam int O_DL   = O_USE + USE_BITS;
    localparam int O_VAL  = O_DL + TIME_BITS;
    localparam int O_KEY  = O_VAL + VAL_W;
    localparam int WORD_W = O_KEY + KEY_W;

    localparam logic [IDX_W-1:0]     LAST     = IDX_W'(ENTRIES - 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [USE_BITS-1:0]  USE_MAX  = '1;

    t_state                r_state;
    t_state                n_state;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      n_idx;
    logic                  r_eval_vld;
    logic [IDX_W-1:0]      r_eval_idx;
    t_cmd                  r_cmd;
    t_result               r_res;
    t_result               n_res;
    logic [TIME_BITS-1:0]  r_time;
    logic [TIME_BITS-1:0]  n_time;
    logic [CAP_W-1:0]      r_cap;
    logic [ENTRIES-1:0]    r_valid;
    logic [ENTRIES-1:0]    n_valid;
    logic [TIME_BITS-1:0]  r_dl;
    logic [TIME_BITS-1:0]  n_dl;
    logic [IDX_W-1:0]      r_target;
    logic [IDX_W-1:0]      r_old_order;

    // sequencer outputs
    logic w_init_wr;
    logic w_write_st;
    logic w_rd_en;
    logic w_cnt_run;
    logic w_scan_ph;
    logic w_sweep_ph;

    logic                  w_accept;
    logic                  w_probe;
    logic                  w_sweep_hit;
    logic [UW-1:0]         w_usable;
    logic [UW-1:0]         w_cfg_usable;
    logic [SUM_W-1:0]      w_dl_sum;

    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [WORD_W-1:0]     w_wdata;
    logic [WORD_W-1:0]     w_rdata;
    logic [IDX_W-1:0]      w_rd_order;
    logic [USE_BITS-1:0]   w_rd_uses;
    logic [TIME_BITS-1:0]  w_rd_dl;
    logic [VAL_W-1:0]      w_rd_value;
    logic [KEY_W-1:0]      w_rd_key;

    logic                  s_expire;
    t_scan_flags           s_flags;
    logic [IDX_W-1:0]      s_match_slot;
    logic [VAL_W-1:0]      s_match_value;
    logic [TIME_BITS-1:0]  s_match_dl;
    logic [USE_BITS-1:0]   s_match_uses;
    logic [IDX_W-1:0]      s_match_order;
    logic [IDX_W-1:0]      s_free_slot;
    logic [IDX_W-1:0]      s_free_order;
    logic [IDX_W-1:0]      s_vict_slot;
    logic [KEY_W-1:0]      s_vict_key;
    logic [IDX_W-1:0]      s_vict_order;

    logic                  w_do_write;
    logic [IDX_W-1:0]      w_target;
    logic [IDX_W-1:0]      w_old_order;
    logic [WORD_W-1:0]     w_new_word;
    logic [USE_BITS-1:0]   w_bumped;
    t_result               w_res;

    assign w_accept = start && !busy;

    assign w_usable     = (UW'(r_cap) > UW'(ENTRIES)) ? UW'(ENTRIES) : UW'(r_cap);
    assign w_cfg_usable = (UW'(i_cfg_wdata) > UW'(ENTRIES)) ? UW'(ENTRIES) : UW'(i_cfg_wdata);

    assign w_rd_order = w_rdata[0 +: IDX_W];
    assign w_rd_uses  = w_rdata[O_USE +: USE_BITS];
    assign w_rd_dl    = w_rdata[O_DL +: TIME_BITS];
    assign w_rd_value = w_rdata[O_VAL +: VAL_W];
    assign w_rd_key   = w_rdata[O_KEY +: KEY_W];

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_idx == LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_cmd.opcode == OP_GET) begin
                        n_state = ST_SCAN;
                    end else if (i_cmd.opcode == OP_PUT && w_usable != '0) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST) n_state = ST_SCAN_END;
            end
            ST_SCAN_END: n_state = ST_WRITE;
            ST_WRITE: begin
                n_state = w_do_write ? ST_SWEEP : ST_DONE;
            end
            ST_SWEEP: begin
                if (r_idx == LAST) n_state = ST_SWEEP_END;
            end
            ST_SWEEP_END: n_state = ST_DONE;
            ST_DONE:      n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy           = 1'b1;
        o_result_valid = 1'b0;
        w_init_wr      = 1'b0;
        w_write_st     = 1'b0;
        w_rd_en        = 1'b0;
        w_cnt_run      = 1'b0;
        w_scan_ph      = 1'b0;
        w_sweep_ph     = 1'b0;
        case (r_state)
            ST_INIT: begin
                w_init_wr = 1'b1;
                w_cnt_run = 1'b1;
            end
            ST_IDLE: busy = 1'b0;
            ST_SCAN: begin
                w_rd_en   = 1'b1;
                w_cnt_run = 1'b1;
                w_scan_ph = 1'b1;
            end
            ST_SCAN_END: w_scan_ph = 1'b1;
            ST_WRITE:    w_write_st = 1'b1;
            ST_SWEEP: begin
                w_rd_en    = 1'b1;
                w_cnt_run  = 1'b1;
                w_sweep_ph = 1'b1;
            end
            ST_SWEEP_END: w_sweep_ph = 1'b1;
            ST_DONE:      o_result_valid = 1'b1;
            default:      busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (w_cnt_run) begin
            n_idx = (r_idx == LAST) ? '0 : r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_eval_vld <= 1'b0;
        end else begin
            r_idx      <= n_idx;
            r_eval_vld <= w_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval_idx <= r_idx;
    end

    assign w_probe     = r_eval_vld && w_scan_ph;
    assign w_sweep_hit = r_eval_vld && w_sweep_ph &&
                         (r_eval_idx != r_target) && (w_rd_order > r_old_order);

    // ---------------- item, time, capacity ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
        end
    end

    always_comb begin
        n_time = r_time;
        if (w_accept && i_cmd.opcode == OP_TICK && r_time != TIME_MAX) begin
            n_time = r_time + TIME_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_cap  <= CAP_RESET;
        end else begin
            r_time <= n_time;
            if (i_cfg_we) r_cap <= i_cfg_wdata;
        end
    end

    // deadline held at the top of the time range
    always_comb begin
        w_dl_sum = SUM_W'(r_time) + SUM_W'(r_cmd.lifetime);
        n_dl     = (w_dl_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : w_dl_sum[TIME_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN) begin
            r_dl <= n_dl;
        end
    end

    // ---------------- entry storage ----------------
    lfuttl_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_rd_en),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    lfuttl_scan #(
        .ENTRIES   (ENTRIES),
        .TIME_BITS (TIME_BITS),
        .USE_BITS  (USE_BITS),
        .UW        (UW)
    ) u_scan (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_clear          (w_accept),
        .i_probe          (w_probe),
        .i_idx            (r_eval_idx),
        .i_valid          (r_valid[r_eval_idx]),
        .i_key            (w_rd_key),
        .i_value          (w_rd_value),
        .i_deadline       (w_rd_dl),
        .i_uses           (w_rd_uses),
        .i_order          (w_rd_order),
        .i_search_key     (r_cmd.key),
        .i_time           (r_time),
        .i_usable         (w_usable),
        .o_expire         (s_expire),
        .o_flags          (s_flags),
        .o_match_slot     (s_match_slot),
        .o_match_value    (s_match_value),
        .o_match_deadline (s_match_dl),
        .o_match_uses     (s_match_uses),
        .o_match_order    (s_match_order),
        .o_free_slot      (s_free_slot),
        .o_free_order     (s_free_order),
        .o_vict_slot      (s_vict_slot),
        .o_vict_key       (s_vict_key),
        .o_vict_order     (s_vict_order)
    );

    // ---------------- update decision ----------------
    assign w_bumped = (s_match_uses == USE_MAX) ? s_match_uses
                                                : s_match_uses + USE_BITS'(1);

    always_comb begin
        w_do_write  = 1'b0;
        w_target    = s_match_slot;
        w_old_order = s_match_order;
        w_new_word  = {r_cmd.key, r_cmd.data_value, r_dl, USE_BITS'(1), LAST};
        w_res.hit         = 1'b0;
        w_res.read_value  = READ_MISS;
        w_res.evicted     = 1'b0;
        w_res.evicted_key = '0;
        case (r_cmd.opcode)
            OP_GET: begin
                if (s_flags.match_found) begin
                    w_do_write       = 1'b1;
                    w_res.hit        = 1'b1;
                    w_res.read_value = s_match_value;
                    w_new_word = {r_cmd.key, s_match_value, s_match_dl, w_bumped, LAST};
                end
            end
            OP_PUT: begin
                w_do_write = 1'b1;
                if (s_flags.match_found) begin
                    w_res.hit  = 1'b1;
                    w_new_word = {r_cmd.key, r_cmd.data_value, r_dl, w_bumped, LAST};
                end else if (s_flags.free_found) begin
                    w_target    = s_free_slot;
                    w_old_order = s_free_order;
                end else begin
                    w_target          = s_vict_slot;
                    w_old_order       = s_vict_order;
                    w_res.evicted     = 1'b1;
                    w_res.evicted_key = s_vict_key;
                end
            end
            default: w_do_write = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_write_st) begin
            r_target    <= w_target;
            r_old_order <= w_old_order;
        end
    end

    // memory write: setup pass, chosen entry, then rank aging
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = WORD_W'(r_idx);
        if (w_init_wr) begin
            w_we = 1'b1;
        end else if (w_write_st) begin
            w_we    = w_do_write;
            w_waddr = w_target;
            w_wdata = w_new_word;
        end else if (w_sweep_hit) begin
            w_we    = 1'b1;
            w_waddr = r_eval_idx;
            w_wdata = {w_rdata[WORD_W-1:IDX_W], w_rd_order - IDX_W'(1)};
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_probe && s_expire) begin
            n_valid[r_eval_idx] = 1'b0;
        end
        if (w_write_st && w_do_write) begin
            n_valid[w_target] = 1'b1;
        end
        if (i_cfg_we) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (UW'(i) >= w_cfg_usable) n_valid[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // ---------------- result ----------------
    always_comb begin
        n_res = r_res;
        if (w_accept) begin
            n_res.hit         = 1'b0;
            n_res.read_value  = READ_MISS;
            n_res.evicted     = 1'b0;
            n_res.evicted_key = '0;
        end else if (w_write_st) begin
            n_res = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_result = r_res;

`ifndef SYNTHESIS
    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !busy)
        else $error("block not idle after a result");

    a_evict_put_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.evicted) |-> (r_cmd.opcode == OP_PUT && !o_result.hit))
        else $error("eviction reported outside a missing put");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd.opcode == OP_TICK && r_time != TIME_MAX)
        |=> (r_time == $past(r_time) + TIME_BITS'(1)))
        else $error("tick did not advance time");

    a_target_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_write_st && w_do_write && !i_cfg_we) |=> r_valid[r_target])
        else $error("written entry not marked valid");
`endif

endmodule
